@@ hdl/utf8d_pkg.sv @@
// Shared types, constants and the byte classifier for the UTF-8 stream decoder.
// No dependencies; every other file of the decoder uses this package.
package utf8d_pkg;

  localparam int CP_W       = 21;
  localparam int BYTE_W     = 8;
  localparam int LEFT_W     = 2;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam logic [LEFT_W-1:0] LEFT_NONE  = 2'd0;
  localparam logic [LEFT_W-1:0] LEFT_ONE   = 2'd1;
  localparam logic [LEFT_W-1:0] LEFT_TWO   = 2'd2;
  localparam logic [LEFT_W-1:0] LEFT_THREE = 2'd3;

  typedef enum logic [2:0] {
    BYTE_ASCII,
    BYTE_CONT,
    BYTE_LEAD2,
    BYTE_LEAD3,
    BYTE_LEAD4,
    BYTE_BAD
  } byte_class_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            is_error;
    logic            last_of_run;
  } result_t;

  // Results produced by one accepted byte, oldest first.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic byte_class_t classify(input logic [BYTE_W-1:0] b);
    byte_class_t c;
    case (b) inside
      8'b0???_????: c = BYTE_ASCII;
      8'b10??_????: c = BYTE_CONT;
      8'b110?_????: c = BYTE_LEAD2;
      8'b1110_????: c = BYTE_LEAD3;
      8'b1111_0???: c = BYTE_LEAD4;
      default:      c = BYTE_BAD;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/utf8d_if.sv @@
// Valid/ready channel interfaces for the byte input and the decoded result output.
// Depends on utf8d_pkg for field widths.
interface utf8d_byte_if;
  logic                           valid;
  logic                           ready;
  logic [utf8d_pkg::BYTE_W-1:0]   in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface utf8d_result_if;
  logic                         valid;
  logic                         ready;
  logic [utf8d_pkg::CP_W-1:0]   code_point;
  logic                         is_error;
  logic                         last_of_run;

  modport source (output valid, output code_point, output is_error, output last_of_run,
                  input ready);
  modport sink   (input valid, input code_point, input is_error, input last_of_run,
                  output ready);
endinterface

@@ hdl/utf8d_core.sv @@
// Decoder state (accumulator, pending continuation count, error flag) and byte decode.
// Depends on utf8d_pkg; produces up to two results per accepted byte.
module utf8d_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic [utf8d_pkg::BYTE_W-1:0]  in_byte,
  output utf8d_pkg::push_t              push
);
  import utf8d_pkg::*;

  logic [CP_W-1:0]   code_accum_r, code_accum_nxt;
  logic [LEFT_W-1:0] bytes_left_r, bytes_left_nxt;
  logic              in_error_r, in_error_nxt;

  byte_class_t cls;
  logic        interrupt;
  logic        own_valid;
  result_t     own_res;
  result_t     err_res;

  always_comb begin
    cls            = classify(in_byte);
    code_accum_nxt = code_accum_r;
    bytes_left_nxt = bytes_left_r;
    in_error_nxt   = in_error_r;
    interrupt      = 1'b0;
    own_valid      = 1'b0;
    own_res        = '0;
    err_res        = '0;
    err_res.is_error = 1'b1;

    if (cls != BYTE_CONT) begin
      interrupt    = (bytes_left_r != LEFT_NONE) || in_error_r;
      in_error_nxt = 1'b0;
      case (cls)
        BYTE_LEAD4: begin
          code_accum_nxt = CP_W'(in_byte[2:0]);
          bytes_left_nxt = LEFT_THREE;
        end
        BYTE_LEAD3: begin
          code_accum_nxt = CP_W'(in_byte[3:0]);
          bytes_left_nxt = LEFT_TWO;
        end
        BYTE_LEAD2: begin
          code_accum_nxt = CP_W'(in_byte[4:0]);
          bytes_left_nxt = LEFT_ONE;
        end
        BYTE_ASCII: begin
          code_accum_nxt     = CP_W'(in_byte[6:0]);
          bytes_left_nxt     = LEFT_NONE;
          own_valid          = 1'b1;
          own_res.code_point = CP_W'(in_byte[6:0]);
        end
        default: begin
          bytes_left_nxt = LEFT_NONE;
          own_valid      = 1'b1;
          own_res        = err_res;
        end
      endcase
    end else if (bytes_left_r != LEFT_NONE) begin
      code_accum_nxt = {code_accum_r[CP_W-7:0], in_byte[5:0]};
      bytes_left_nxt = bytes_left_r - LEFT_ONE;
      if (bytes_left_r == LEFT_ONE) begin
        own_valid          = 1'b1;
        own_res.code_point = {code_accum_r[CP_W-7:0], in_byte[5:0]};
      end
    end else begin
      in_error_nxt = 1'b1;
    end

    push.count  = {1'b0, interrupt} + {1'b0, own_valid};
    push.first  = interrupt ? err_res : own_res;
    push.second = own_res;
    push.first.last_of_run  = !(interrupt && own_valid);
    push.second.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_accum_r <= '0;
      bytes_left_r <= LEFT_NONE;
      in_error_r   <= 1'b0;
    end else if (take) begin
      code_accum_r <= code_accum_nxt;
      bytes_left_r <= bytes_left_nxt;
      in_error_r   <= in_error_nxt;
    end
  end

  a_error_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (bytes_left_r != LEFT_NONE) |-> !in_error_r)
    else $error("error flag set while a sequence is open");

  a_cont_never_pushes_two: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cls == BYTE_CONT) |-> (push.count != 2'd2))
    else $error("continuation byte produced two results");

  a_open_seq_pushes_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cls != BYTE_ASCII && cls != BYTE_BAD && cls != BYTE_CONT
     && bytes_left_r == LEFT_NONE && !in_error_r) |-> (push.count == 2'd0))
    else $error("lead byte of a multi-byte sequence produced a result");

endmodule

@@ hdl/utf8_stream_decoder_top.sv @@
// Top level of the lenient UTF-8 stream decoder: decode core plus a four-entry result queue.
// Depends on utf8d_pkg, utf8d_if and utf8d_core.
//
//   channel   dir  payload                               handshake
//   in_if     in   in_byte[7:0]                          valid/ready
//   out_if    out  code_point[20:0], is_error, last_of_run valid/ready
//
// A byte is decoded in the cycle it is accepted; its results enter the queue at that edge
// and can leave from the next cycle on, one word per cycle while out_if.ready is high.
// Input is taken whenever the queue has room for two results, so one byte per cycle is
// sustained while each byte yields at most one result; a byte with two results puts an
// extra word in the queue. A stalled output fills the queue and then holds the input off.
// Synchronous active-low reset empties the queue and clears the decoder state.
module utf8_stream_decoder_top (
  input  logic                   clk,
  input  logic                   rst_n,
  utf8d_byte_if.sink             in_if,
  utf8d_result_if.source         out_if
);
  import utf8d_pkg::*;

  result_t            q_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               take;
  logic               pop;
  logic [1:0]         n_push;
  push_t              push;
  result_t            head;

  utf8d_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_if.in_byte),
    .push    (push)
  );

  assign in_if.ready = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign take        = in_if.valid && in_if.ready;
  assign pop         = out_if.valid && out_if.ready;
  assign n_push      = take ? push.count : 2'd0;

  assign head               = q_r[rd_ptr_r];
  assign out_if.valid       = (cnt_r != '0);
  assign out_if.code_point  = head.code_point;
  assign out_if.is_error    = head.is_error;
  assign out_if.last_of_run = head.last_of_run;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + QCNT_W'(n_push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= push.first;
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr_r + QPTR_W'(1)] <= push.second;
    end
  end

  a_queue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_error_has_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.is_error) |-> (out_if.code_point == '0))
    else $error("error result carries a code point");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (cnt_r == QCNT_W'($past(cnt_r) + QCNT_W'($past(n_push)) - QCNT_W'($past(pop))))
    || !$past(rst_n))
    else $error("queue count does not match pushes and pops");

  a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (QPTR_W'(wr_ptr_r - rd_ptr_r) == cnt_r[QPTR_W-1:0]))
    else $error("queue pointers disagree with count");

endmodule

@@ dv/tb_utf8_stream_decoder_top.sv @@
// Self-checking testbench for the lenient UTF-8 stream decoder top level.
// Drives raw bytes, predicts the code points and errors, and checks every result word.
// Depends on utf8d_pkg, utf8d_if and the utf8_stream_decoder_top RTL.
module tb_utf8_stream_decoder_top;
  import utf8d_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 100;

  logic clk;
  logic rst_n;

  utf8d_byte_if   in_if();
  utf8d_result_if out_if();

  utf8_stream_decoder_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  logic [CP_W-1:0]   mdl_accum;
  logic [LEFT_W-1:0] mdl_left;
  logic              mdl_err;

  result_t awaited_codes[$];
  int      mismatch_count = 0;
  int      bytes_sent = 0;
  int      quiet_cycles = 0;
  int      hold_len = 0;
  bit      idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic byte_class_t byte_kind(input logic [BYTE_W-1:0] b);
    if (b[7] == 1'b0) return BYTE_ASCII;
    if (b[7:6] == 2'b10) return BYTE_CONT;
    if (b[7:5] == 3'b110) return BYTE_LEAD2;
    if (b[7:4] == 4'b1110) return BYTE_LEAD3;
    if (b[7:3] == 5'b11110) return BYTE_LEAD4;
    return BYTE_BAD;
  endfunction

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    result_t     got[2];
    int          n;
    byte_class_t kind;
    n = 0;
    kind = byte_kind(b);
    got[0] = '0;
    got[1] = '0;
    if (kind != BYTE_CONT) begin
      if (mdl_left != LEFT_NONE || mdl_err) begin
        got[n].is_error = 1'b1;
        n++;
      end
      mdl_err = 1'b0;
      case (kind)
        BYTE_LEAD4: begin
          mdl_accum = {18'd0, b[2:0]};
          mdl_left = LEFT_THREE;
        end
        BYTE_LEAD3: begin
          mdl_accum = {17'd0, b[3:0]};
          mdl_left = LEFT_TWO;
        end
        BYTE_LEAD2: begin
          mdl_accum = {16'd0, b[4:0]};
          mdl_left = LEFT_ONE;
        end
        BYTE_ASCII: begin
          mdl_accum = {14'd0, b[6:0]};
          mdl_left = LEFT_NONE;
          got[n].code_point = mdl_accum;
          n++;
        end
        default: begin
          mdl_left = LEFT_NONE;
          got[n].is_error = 1'b1;
          n++;
        end
      endcase
    end else if (mdl_left != LEFT_NONE) begin
      mdl_accum = {mdl_accum[CP_W-7:0], b[5:0]};
      mdl_left = mdl_left - 2'd1;
      if (mdl_left == LEFT_NONE) begin
        got[n].code_point = mdl_accum;
        n++;
      end
    end else begin
      mdl_err = 1'b1;
    end
    if (n > 0) got[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) awaited_codes.push_back(got[i]);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_seq(input logic [31:0] seq, input int len);
    for (int i = len - 1; i >= 0; i--) send_byte(seq[i*8 +: 8]);
  endtask

  task automatic send_char(input int len, input int keep);
    logic [BYTE_W-1:0] rnd;
    rnd = BYTE_W'($urandom);
    case (len)
      1:       send_byte({1'b0, rnd[6:0]});
      2:       send_byte({3'b110, rnd[4:0]});
      3:       send_byte({4'b1110, rnd[3:0]});
      default: send_byte({5'b11110, rnd[2:0]});
    endcase
    for (int i = 0; i < keep; i++) begin
      rnd = BYTE_W'($urandom);
      send_byte({2'b10, rnd[5:0]});
    end
  endtask

  task automatic random_stream(input int count);
    int                goal;
    int                pick;
    int                len;
    logic [BYTE_W-1:0] rnd;
    goal = bytes_sent + count;
    while (bytes_sent < goal) begin
      pick = $urandom_range(0, 99);
      len = $urandom_range(1, 4);
      rnd = BYTE_W'($urandom);
      if (pick < 75) send_char(len, len - 1);
      else if (pick < 85) send_char(len, (len > 1) ? $urandom_range(0, len - 2) : 0);
      else if (pick < 92) send_byte(rnd);
      else if (pick < 96) send_byte({2'b10, rnd[5:0]});
      else send_byte({5'b11111, rnd[2:0]});
    end
  endtask

  task automatic wait_all_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (awaited_codes.size() != 0);
  endtask

  task automatic test_ascii_extremes();
    send_byte(8'h00);
    send_byte(8'h7F);
  endtask

  task automatic test_multibyte();
    send_seq(32'h0000C2A9, 2);
    send_seq(32'h00E282AC, 3);
    send_seq(32'hF09F9880, 4);
    send_seq(32'hF7BFBFBF, 4);
  endtask

  task automatic test_malformed();
    send_seq(32'h0080BF41, 3);
    send_seq(32'h00E28241, 3);
    send_seq(32'h0000F8FF, 2);
    send_seq(32'h0000C2FC, 2);
  endtask

  task automatic test_random_mix();
    random_stream(330);
  endtask

  task automatic test_output_stall();
    hold_len = LONG_HOLD;
    random_stream(40);
  endtask

  task automatic test_sender_pause();
    random_stream(30);
    wait_all_results();
    random_stream(20);
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    random_stream(110);
  endtask

  initial begin : ready_driver
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        stall_left = hold_len;
        hold_len = 0;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_codes.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result word: cp=%h err=%b last=%b",
                   out_if.code_point, out_if.is_error, out_if.last_of_run);
        mismatch_count++;
      end else begin
        want = awaited_codes.pop_front();
        if (out_if.code_point !== want.code_point || out_if.is_error !== want.is_error ||
            out_if.last_of_run !== want.last_of_run) begin
          if (mismatch_count < 10)
            $display("mismatch: expected cp=%h err=%b last=%b, got cp=%h err=%b last=%b",
                     want.code_point, want.is_error, want.last_of_run,
                     out_if.code_point, out_if.is_error, out_if.last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.in_byte <= '0;
    mdl_accum = '0;
    mdl_left = LEFT_NONE;
    mdl_err = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_ascii_extremes();
    test_multibyte();
    test_malformed();
    test_random_mix();
    test_output_stall();
    test_sender_pause();
    test_full_rate();

    wait_all_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && awaited_codes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
